// File: design/rpmg_pkg.sv
// Shared types, codes and default sizes for the randomized Prim maze generator.
// Used by rpmg_ctrl, rpmg_dpath and the top level; depends on nothing.
package rpmg_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_COLUMNS    = 16;
  localparam int DEF_MAX_ROWS       = 16;
  localparam int DEF_FRONTIER_DEPTH = 1024;
  localparam int DEF_RANDOM_BITS    = 16;

  // Fixed field widths.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int GRID_W    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  // Edge directions, in neighbor expansion order.
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  // What a result shows.
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_EDGE  = 2'd1,
    RES_OPEN  = 2'd2,
    RES_WALLS = 2'd3
  } res_e;

  typedef enum logic [3:0] {
    S_CLEAR   = 4'd0,
    S_SEED    = 4'd1,
    S_IDLE    = 4'd2,
    S_DIV     = 4'd3,
    S_RD_EDGE = 4'd4,
    S_LATCH   = 4'd5,
    S_SHIFT   = 4'd6,
    S_VREAD   = 4'd7,
    S_VCHK    = 4'd8,
    S_NB_RD   = 4'd9,
    S_NB_CHK  = 4'd10,
    S_QRD     = 4'd11,
    S_QCHK    = 4'd12,
    S_RESULT  = 4'd13
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear;
    logic seed;
    logic div_step;
    logic rd_edge;
    logic latch_edge;
    logic shift;
    logic dec;
    logic vread;
    logic open;
    logic nb_read;
    logic nb_push;
    logic nb_next;
    logic q_read;
    logic q_latch;
    logic load_out;
    res_e res;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic clear_last;
    logic div_last;
    logic shift_done;
    logic visited;
    logic nb_in_grid;
    logic nb_last;
  } stat_t;

endpackage

// File: design/rpmg_ctrl.sv
// Sequencing state machine of the maze generator and the output valid flag.
// Depends on rpmg_pkg; drives the commands of rpmg_dpath.
module rpmg_ctrl import rpmg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  stat_t       stat_i,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;
  res_e   res_q, res_d;
  logic   start_q, start_d;
  logic   out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    start_d = start_q;
    case (state_q)
      S_CLEAR: begin
        if (stat_i.clear_last) begin
          state_d = start_q ? S_SEED : S_IDLE;
        end
      end
      S_SEED: begin
        res_d   = RES_NONE;
        state_d = S_RESULT;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_START: begin
              start_d = 1'b1;
              state_d = S_CLEAR;
            end
            KIND_STEP: begin
              res_d   = RES_NONE;
              state_d = stat_i.count_zero ? S_RESULT : S_DIV;
            end
            KIND_QUERY: state_d = S_QRD;
            default: begin
              res_d   = RES_NONE;
              state_d = S_RESULT;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat_i.div_last) state_d = S_RD_EDGE;
      end
      S_RD_EDGE: state_d = S_LATCH;
      S_LATCH:   state_d = S_SHIFT;
      S_SHIFT: begin
        if (stat_i.shift_done) state_d = S_VREAD;
      end
      S_VREAD: state_d = S_VCHK;
      S_VCHK: begin
        if (stat_i.visited) begin
          res_d   = RES_EDGE;
          state_d = S_RESULT;
        end else begin
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        if (stat_i.nb_in_grid) begin
          state_d = S_NB_CHK;
        end else if (stat_i.nb_last) begin
          res_d   = RES_OPEN;
          state_d = S_RESULT;
        end
      end
      S_NB_CHK: begin
        if (stat_i.nb_last) begin
          res_d   = RES_OPEN;
          state_d = S_RESULT;
        end else begin
          state_d = S_NB_RD;
        end
      end
      S_QRD:  state_d = S_QCHK;
      S_QCHK: begin
        res_d   = RES_WALLS;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd_o     = '0;
    cmd_o.res = res_q;
    case (state_q)
      S_CLEAR:   cmd_o.clear = 1'b1;
      S_SEED:    cmd_o.seed = 1'b1;
      S_IDLE:    cmd_o.accept = in_valid_i;
      S_DIV:     cmd_o.div_step = 1'b1;
      S_RD_EDGE: cmd_o.rd_edge = 1'b1;
      S_LATCH:   cmd_o.latch_edge = 1'b1;
      S_SHIFT:   cmd_o.shift = 1'b1;
      S_VREAD: begin
        cmd_o.vread = 1'b1;
        cmd_o.dec   = 1'b1;
      end
      S_VCHK:    cmd_o.open = !stat_i.visited;
      S_NB_RD: begin
        cmd_o.nb_read = stat_i.nb_in_grid;
        cmd_o.nb_next = !stat_i.nb_in_grid && !stat_i.nb_last;
      end
      S_NB_CHK: begin
        cmd_o.nb_push = 1'b1;
        cmd_o.nb_next = !stat_i.nb_last;
      end
      S_QRD:     cmd_o.q_read = 1'b1;
      S_QCHK:    cmd_o.q_latch = 1'b1;
      S_RESULT:  cmd_o.load_out = !out_valid_q || !out_stall_i;
      default:   cmd_o = '0;
    endcase
  end

  // The output register holds a result until its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_q       <= RES_NONE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // An accepted item keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

endmodule

// File: design/rpmg_dpath.sv
// Datapath of the maze generator: cell stores, frontier memory, divider, result register.
// Depends on rpmg_pkg; driven by the commands of rpmg_ctrl.
module rpmg_dpath import rpmg_pkg::*; #(
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int FRONTIER_DEPTH = DEF_FRONTIER_DEPTH,
  parameter int RANDOM_BITS    = DEF_RANDOM_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [15:0]          random_word_i,
  input  logic [3:0]           query_x_i,
  input  logic [3:0]           query_y_i,
  output logic                 opened_o,
  output logic [3:0]           from_x_o,
  output logic [3:0]           from_y_o,
  output logic [3:0]           to_x_o,
  output logic [3:0]           to_y_o,
  output logic                 finished_o,
  output logic                 wall_right_o,
  output logic                 wall_down_o,
  output logic [10:0]          frontier_left_o
);

  localparam int CX_W  = $clog2(MAX_COLUMNS);
  localparam int CY_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int CA_W  = $clog2(CELLS);
  localparam int AW    = $clog2(FRONTIER_DEPTH);
  localparam int CNT_W = $clog2(FRONTIER_DEPTH + 1);
  localparam int EW    = CX_W + CY_W + 2;
  localparam int RBC_W = $clog2(RANDOM_BITS);

  localparam logic [CA_W-1:0]   MC        = CA_W'(MAX_COLUMNS);
  localparam logic [CA_W-1:0]   LAST_CELL = CA_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  DEPTH     = CNT_W'(FRONTIER_DEPTH);
  localparam logic [GRID_W-1:0] GMAX_C    = GRID_W'(MAX_COLUMNS);
  localparam logic [GRID_W-1:0] GMAX_R    = GRID_W'(MAX_ROWS);

  // Configuration registers and the grid size they select.
  logic [CFG_W-1:0]  cols_q, rows_q;
  logic [GRID_W-1:0] cols_raw, rows_raw, cols_eff, rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_RESET;
      rows_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COLUMNS: cols_q <= cfg_data_i;
        REG_ROWS:    rows_q <= cfg_data_i;
        default:     cols_q <= cols_q;
      endcase
    end
  end

  assign cols_raw = GRID_W'(cols_q);
  assign rows_raw = GRID_W'(rows_q);
  assign cols_eff = (cols_raw < GRID_W'(2)) ? GRID_W'(2) :
                    (cols_raw > GMAX_C) ? GMAX_C : cols_raw;
  assign rows_eff = (rows_raw < GRID_W'(1)) ? GRID_W'(1) :
                    (rows_raw > GMAX_R) ? GMAX_R : rows_raw;

  // Control registers.
  logic [CNT_W-1:0] count_q, count_d;
  logic [CA_W-1:0]  clr_addr_q;
  logic             pend_q;

  // Working registers.
  logic [RANDOM_BITS-1:0] rnd_q;
  logic [RBC_W-1:0]       div_cnt_q;
  logic [CNT_W-1:0]       rem_q;
  logic [CNT_W-1:0]       sh_ptr_q;
  logic [AW-1:0]          pa_q;
  logic [CX_W-1:0]        efx_q;
  logic [CY_W-1:0]        efy_q;
  dir_e                   edir_q;
  dir_e                   nb_d_q;
  logic [3:0]             qx_q, qy_q;
  logic                   wr_q, wd_q;

  // Memory read data.
  logic          vis_rd_q, or_rd_q, od_rd_q;
  logic [EW-1:0] fr_rd_q;

  // Target cell of the chosen edge.
  logic [CX_W-1:0] tx;
  logic [CY_W-1:0] ty;
  always_comb begin
    tx = efx_q;
    ty = efy_q;
    case (edir_q)
      DIR_UP:    ty = efy_q - 1'b1;
      DIR_LEFT:  tx = efx_q - 1'b1;
      DIR_DOWN:  ty = efy_q + 1'b1;
      DIR_RIGHT: tx = efx_q + 1'b1;
      default:   tx = efx_q;
    endcase
  end

  logic [CA_W-1:0] from_cell, to_cell, open_addr;
  logic            horiz;
  assign from_cell = CA_W'(efy_q) * MC + CA_W'(efx_q);
  assign to_cell   = CA_W'(ty) * MC + CA_W'(tx);
  assign horiz     = (edir_q == DIR_LEFT) || (edir_q == DIR_RIGHT);
  // The passage bit lives in the upper or left cell of the pair.
  assign open_addr = ((edir_q == DIR_RIGHT) || (edir_q == DIR_DOWN)) ? from_cell : to_cell;

  // Neighbor of the target under test.
  logic [CX_W-1:0] nx;
  logic [CY_W-1:0] ny;
  logic            nb_in;
  always_comb begin
    nx    = tx;
    ny    = ty;
    nb_in = 1'b0;
    case (nb_d_q)
      DIR_UP: begin
        ny    = ty - 1'b1;
        nb_in = (ty != '0);
      end
      DIR_LEFT: begin
        nx    = tx - 1'b1;
        nb_in = (tx != '0);
      end
      DIR_DOWN: begin
        ny    = ty + 1'b1;
        nb_in = (GRID_W'(ty) + GRID_W'(1)) < rows_eff;
      end
      DIR_RIGHT: begin
        nx    = tx + 1'b1;
        nb_in = (GRID_W'(tx) + GRID_W'(1)) < cols_eff;
      end
      default: nb_in = 1'b0;
    endcase
    // A target left over from a larger grid may lie outside the current one.
    nb_in = nb_in && (GRID_W'(nx) < cols_eff) && (GRID_W'(ny) < rows_eff);
  end

  logic [CA_W-1:0] nb_cell;
  assign nb_cell = CA_W'(ny) * MC + CA_W'(nx);

  // Queried cell.
  logic            q_in, q_right, q_down;
  logic [CA_W-1:0] q_cell;
  assign q_in    = (GRID_W'(qx_q) < cols_eff) && (GRID_W'(qy_q) < rows_eff);
  assign q_right = (GRID_W'(qx_q) + GRID_W'(1)) < cols_eff;
  assign q_down  = (GRID_W'(qy_q) + GRID_W'(1)) < rows_eff;
  assign q_cell  = q_in ? (CA_W'(qy_q) * MC + CA_W'(qx_q)) : '0;

  // Divider step: shift in one bit of the random word, subtract when it fits.
  logic [CNT_W:0] div_sh, div_sub;
  assign div_sh  = {rem_q, rnd_q[RANDOM_BITS-1]};
  assign div_sub = div_sh - (CNT_W+1)'(count_q);

  // Frontier compaction pointer.
  logic sh_more, room, do_push;
  assign sh_more = sh_ptr_q < count_q;
  assign room    = count_q < DEPTH;
  assign do_push = cmd_i.nb_push && !vis_rd_q && room;

  // Random word reduced to the bits in use.
  logic [RANDOM_BITS+15:0] rw_ext;
  assign rw_ext = (RANDOM_BITS+16)'(random_word_i);

  // Cell store ports.
  logic            vis_we, vis_wd, vis_re, or_we, od_we, cell_wd;
  logic [CA_W-1:0] vis_wa, vis_ra, cell_wa;
  assign vis_we  = cmd_i.clear || cmd_i.seed || cmd_i.open;
  assign vis_wa  = cmd_i.clear ? clr_addr_q : (cmd_i.seed ? '0 : to_cell);
  assign vis_wd  = !cmd_i.clear;
  assign vis_re  = cmd_i.vread || cmd_i.nb_read;
  assign vis_ra  = cmd_i.vread ? to_cell : nb_cell;
  assign or_we   = cmd_i.clear || (cmd_i.open && horiz);
  assign od_we   = cmd_i.clear || (cmd_i.open && !horiz);
  assign cell_wa = cmd_i.clear ? clr_addr_q : open_addr;
  assign cell_wd = !cmd_i.clear;

  // Frontier memory ports.
  logic          fr_we, fr_re;
  logic [AW-1:0] fr_wa, fr_ra;
  logic [EW-1:0] fr_wd, seed_edge;
  assign seed_edge = {CX_W'(0), CY_W'(0), DIR_RIGHT};
  assign fr_we = cmd_i.seed || (cmd_i.shift && pend_q) || do_push;
  assign fr_wa = cmd_i.seed ? '0 : (cmd_i.shift ? (pa_q - 1'b1) : count_q[AW-1:0]);
  assign fr_wd = cmd_i.seed ? seed_edge : (cmd_i.shift ? fr_rd_q : {tx, ty, nb_d_q});
  assign fr_re = cmd_i.rd_edge || (cmd_i.shift && sh_more);
  assign fr_ra = cmd_i.rd_edge ? rem_q[AW-1:0] : sh_ptr_q[AW-1:0];

  // Memories.
  logic          vis_mem [CELLS];
  logic          or_mem  [CELLS];
  logic          od_mem  [CELLS];
  logic [EW-1:0] fr_mem  [FRONTIER_DEPTH];

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_rd_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk_i) begin
    if (or_we) or_mem[cell_wa] <= cell_wd;
    if (od_we) od_mem[cell_wa] <= cell_wd;
    if (cmd_i.q_read) begin
      or_rd_q <= or_mem[q_cell];
      od_rd_q <= od_mem[q_cell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    if (fr_re) fr_rd_q <= fr_mem[fr_ra];
  end

  // Frontier count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.seed) begin
      count_d = CNT_W'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - 1'b1;
    end else if (do_push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      clr_addr_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= cmd_i.shift && sh_more;
      if (cmd_i.clear) begin
        clr_addr_q <= (clr_addr_q == LAST_CELL) ? '0 : clr_addr_q + 1'b1;
      end
    end
  end

  // Working registers of a step or query.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rnd_q     <= rw_ext[RANDOM_BITS-1:0];
      div_cnt_q <= RBC_W'(RANDOM_BITS - 1);
      rem_q     <= '0;
      qx_q      <= query_x_i;
      qy_q      <= query_y_i;
    end
    if (cmd_i.div_step) begin
      rnd_q     <= rnd_q << 1;
      div_cnt_q <= div_cnt_q - 1'b1;
      rem_q     <= div_sh >= (CNT_W+1)'(count_q) ? div_sub[CNT_W-1:0] : div_sh[CNT_W-1:0];
    end
    if (cmd_i.rd_edge) begin
      sh_ptr_q <= rem_q + 1'b1;
    end
    if (cmd_i.shift && sh_more) begin
      sh_ptr_q <= sh_ptr_q + 1'b1;
      pa_q     <= sh_ptr_q[AW-1:0];
    end
    if (cmd_i.latch_edge) begin
      efx_q  <= fr_rd_q[EW-1 -: CX_W];
      efy_q  <= fr_rd_q[CY_W+1:2];
      edir_q <= dir_e'(fr_rd_q[1:0]);
    end
    if (cmd_i.open) begin
      nb_d_q <= DIR_UP;
    end else if (cmd_i.nb_next || (cmd_i.nb_push && nb_d_q != DIR_RIGHT)) begin
      nb_d_q <= dir_e'(nb_d_q + 2'd1);
    end
    if (cmd_i.q_latch) begin
      wr_q <= q_in && q_right && !or_rd_q;
      wd_q <= q_in && q_down && !od_rd_q;
    end
  end

  // Result register.
  logic [CX_W+3:0]  efx_ext, tx_ext;
  logic [CY_W+3:0]  efy_ext, ty_ext;
  logic [CNT_W+10:0] cnt_ext;
  logic             show;
  assign efx_ext = (CX_W+4)'(efx_q);
  assign tx_ext  = (CX_W+4)'(tx);
  assign efy_ext = (CY_W+4)'(efy_q);
  assign ty_ext  = (CY_W+4)'(ty);
  assign cnt_ext = (CNT_W+11)'(count_q);
  assign show    = (cmd_i.res == RES_EDGE) || (cmd_i.res == RES_OPEN);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      opened_o        <= (cmd_i.res == RES_OPEN);
      from_x_o        <= show ? efx_ext[3:0] : 4'd0;
      from_y_o        <= show ? efy_ext[3:0] : 4'd0;
      to_x_o          <= show ? tx_ext[3:0] : 4'd0;
      to_y_o          <= show ? ty_ext[3:0] : 4'd0;
      finished_o      <= (count_q == '0);
      wall_right_o    <= (cmd_i.res == RES_WALLS) && wr_q;
      wall_down_o     <= (cmd_i.res == RES_WALLS) && wd_q;
      frontier_left_o <= cnt_ext[10:0];
    end
  end

  // Status.
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.clear_last = (clr_addr_q == LAST_CELL);
  assign stat_o.div_last   = (div_cnt_q == '0);
  assign stat_o.shift_done = !sh_more && !pend_q;
  assign stat_o.visited    = vis_rd_q;
  assign stat_o.nb_in_grid = nb_in;
  assign stat_o.nb_last    = (nb_d_q == DIR_RIGHT);

  // The frontier never grows past its depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH)
    else $error("frontier count beyond depth");

  // The chosen index always names a live frontier entry.
  a_index_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_edge |-> (rem_q < count_q))
    else $error("frontier index out of range");

endmodule

// File: design/random_prim_maze_generator_unit.sv
// Top level of the randomized Prim maze generator: controller plus datapath.
// Depends on rpmg_pkg, rpmg_ctrl and rpmg_dpath.
//
//   Channel  Direction  Handshake                Payload
//   in       in         in_valid_i / in_stall_o  kind, random_word, query_x, query_y
//   out      out        out_valid_o/out_stall_i  opened .. frontier_left
//   cfg      in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// A step on a non-empty frontier computes a bit-serial remainder, then moves each
// frontier entry behind the chosen one to close the gap in the frontier memory, then,
// if the target cell is unvisited, runs the neighbor checks. A start sweeps the cell
// stores; after reset the same sweep runs before the first item is taken. A new item
// is taken while a result waits.
module random_prim_maze_generator_unit import rpmg_pkg::*; #(
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS       = DEF_MAX_ROWS,
  parameter int FRONTIER_DEPTH = DEF_FRONTIER_DEPTH,
  parameter int RANDOM_BITS    = DEF_RANDOM_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [15:0]          random_word_i,
  input  logic [3:0]           query_x_i,
  input  logic [3:0]           query_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 opened_o,
  output logic [3:0]           from_x_o,
  output logic [3:0]           from_y_o,
  output logic [3:0]           to_x_o,
  output logic [3:0]           to_y_o,
  output logic                 finished_o,
  output logic                 wall_right_o,
  output logic                 wall_down_o,
  output logic [10:0]          frontier_left_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing.
  rpmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  rpmg_dpath #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .MAX_ROWS       (MAX_ROWS),
    .FRONTIER_DEPTH (FRONTIER_DEPTH),
    .RANDOM_BITS    (RANDOM_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .random_word_i   (random_word_i),
    .query_x_i       (query_x_i),
    .query_y_i       (query_y_i),
    .opened_o        (opened_o),
    .from_x_o        (from_x_o),
    .from_y_o        (from_y_o),
    .to_x_o          (to_x_o),
    .to_y_o          (to_y_o),
    .finished_o      (finished_o),
    .wall_right_o    (wall_right_o),
    .wall_down_o     (wall_down_o),
    .frontier_left_o (frontier_left_o)
  );

endmodule
